>>> src/assert_macros.svh
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, quiet during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/pdf_pkg.sv
// Types and constants of the preamble packet deframer.
package pdf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned POS_W = 2;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_PREAMBLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESYNC = 2'd3;

   localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DATA = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GOOD_END = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SYNC_ERR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LEN_ERR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SUM_ERR = 3'd5;

   localparam logic [1:0] REG_SYNC_FIRST = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_SYNC_THIRD = 2'd2;
   localparam logic [1:0] REG_MIN_LENGTH = 2'd3;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET = 8'h03;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hEF;
   localparam logic [BYTE_W-1:0] SYNC_THIRD_RESET = 8'hAF;
   localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET = 8'd8;
   localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_byte_first;
      logic [BYTE_W-1:0] sync_byte_second;
      logic [BYTE_W-1:0] sync_byte_third;
      logic [BYTE_W-1:0] min_frame_length;
   } cfg_type;

endpackage

>>> src/pdf_csr.sv
// Configuration register bank with an APB-style access port.
module pdf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pdf_pkg::cfg_type                  cfg
);
   import pdf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic write_en;
   logic [BYTE_W-1:0] read_byte;

   assign reg_index = csr_paddr[3:2];
   assign write_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_SYNC_FIRST: cfg_in.sync_byte_first = csr_pwdata[BYTE_W-1:0];
            REG_SYNC_SECOND: cfg_in.sync_byte_second = csr_pwdata[BYTE_W-1:0];
            REG_SYNC_THIRD: cfg_in.sync_byte_third = csr_pwdata[BYTE_W-1:0];
            REG_MIN_LENGTH: cfg_in.min_frame_length = csr_pwdata[BYTE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SYNC_FIRST: read_byte = cfg_ff.sync_byte_first;
         REG_SYNC_SECOND: read_byte = cfg_ff.sync_byte_second;
         REG_SYNC_THIRD: read_byte = cfg_ff.sync_byte_third;
         REG_MIN_LENGTH: read_byte = cfg_ff.min_frame_length;
         default: read_byte = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, read_byte};
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte_first <= SYNC_FIRST_RESET;
         cfg_ff.sync_byte_second <= SYNC_SECOND_RESET;
         cfg_ff.sync_byte_third <= SYNC_THIRD_RESET;
         cfg_ff.min_frame_length <= MIN_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/pdf_parser.sv
// Input register, frame parse state and result register of the deframer.
`include "assert_macros.svh"

module pdf_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  pdf_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pdf_pkg::BYTE_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pdf_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic [pdf_pkg::KIND_W-1:0]    rsp_tuser
);
   import pdf_pkg::*;

   logic in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_value_ff, out_value_in;

   logic advance;
   logic process;
   logic [BYTE_W-1:0] sum;
   logic [BYTE_W-1:0] expected;
   logic [BYTE_W-1:0] left_dec;
   logic sync_match;

   assign advance = !out_valid_ff || rsp_tready;
   assign process = advance && in_valid_ff;
   assign req_tready = !in_valid_ff || advance;

   assign sum = xor_ff ^ in_byte_ff;
   assign left_dec = left_ff - 8'd1;
   assign expected = (pos_ff == 2'd0) ? cfg.sync_byte_first :
                     (pos_ff == 2'd1) ? cfg.sync_byte_second : cfg.sync_byte_third;
   assign sync_match = (in_byte_ff == expected);

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      xor_in = sum;
      left_in = left_ff;
      out_valid_in = 1'b0;
      out_kind_in = KIND_DATA;
      out_value_in = '0;
      case (mode_ff)
         MODE_PREAMBLE: begin
            if (!sync_match) begin
               out_valid_in = 1'b1;
               out_kind_in = KIND_SYNC_ERR;
               out_value_in = {{(BYTE_W-POS_W){1'b0}}, pos_ff} + 8'd1;
               xor_in = '0;
               pos_in = '0;
               mode_in = MODE_RESYNC;
            end else if (pos_ff >= 2'd2) begin
               pos_in = '0;
               mode_in = MODE_LENGTH;
            end else begin
               pos_in = pos_ff + 2'd1;
            end
         end
         MODE_LENGTH: begin
            out_valid_in = 1'b1;
            if (in_byte_ff < cfg.min_frame_length) begin
               out_kind_in = KIND_LEN_ERR;
               xor_in = '0;
               pos_in = '0;
               mode_in = MODE_RESYNC;
            end else begin
               out_kind_in = KIND_LENGTH;
               out_value_in = in_byte_ff - FRAME_OVERHEAD;
               left_in = in_byte_ff - FRAME_OVERHEAD;
               mode_in = MODE_PAYLOAD;
            end
         end
         MODE_PAYLOAD: begin
            out_valid_in = 1'b1;
            left_in = left_dec;
            if (left_dec != '0) begin
               out_kind_in = KIND_DATA;
               out_value_in = in_byte_ff;
            end else if (sum != '0) begin
               out_kind_in = KIND_SUM_ERR;
               xor_in = '0;
               pos_in = '0;
               mode_in = MODE_RESYNC;
            end else begin
               out_kind_in = KIND_GOOD_END;
               pos_in = '0;
               mode_in = MODE_PREAMBLE;
            end
         end
         default: begin
            if (sync_match) begin
               if (pos_ff >= 2'd2) begin
                  pos_in = '0;
                  mode_in = MODE_LENGTH;
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end else begin
               pos_in = '0;
               xor_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff <= MODE_PREAMBLE;
         pos_ff <= '0;
         xor_ff <= '0;
         left_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= process && out_valid_in;
         end
         if (process) begin
            mode_ff <= mode_in;
            pos_ff <= pos_in;
            xor_ff <= xor_in;
            left_ff <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (process) begin
         out_kind_ff <= out_kind_in;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_value_ff;
   assign rsp_tuser = out_kind_ff;

   `ASSERT_ALWAYS(a_pos_range, clock, reset || (pos_ff != 2'd3), "preamble position out of range")
   `ASSERT_CLK(a_resync_silent, clock, reset, process && (mode_ff == MODE_RESYNC) |=> !rsp_tvalid, "resync produced a result")
   `ASSERT_CLK(a_good_end_clean, clock, reset, process && out_valid_in && (out_kind_in == KIND_GOOD_END) |=> (mode_ff == MODE_PREAMBLE) && (xor_ff == '0), "good end left dirty state")
   `ASSERT_CLK(a_length_emit, clock, reset, process && (mode_ff == MODE_LENGTH) && (in_byte_ff >= cfg.min_frame_length) |=> rsp_tvalid && (rsp_tuser == KIND_LENGTH) && (mode_ff == MODE_PAYLOAD), "length byte not reported")

endmodule

>>> src/preamble_packet_deframer_core.sv
// Top level of the preamble packet deframer: register bank and byte parser.
// Takes one received byte per transaction and, at a sustained rate of one byte per clock
// while rsp_tready is high, reports the payload length, each data byte, a good end of
// frame or a sync, length or checksum error; bytes that only advance or hunt for the
// preamble give no result. A result lands in the result register once its byte has left
// the input register, where it sits while the parse logic works on it. The input register
// doubles as a skid stage, so one more byte is taken while a result waits on rsp_tready.
module preamble_packet_deframer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] rx_byte
   input  logic [pdf_pkg::BYTE_W-1:0]         req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] out_value
   output logic [pdf_pkg::BYTE_W-1:0]         rsp_tdata,
   // [2:0] out_kind
   output logic [pdf_pkg::KIND_W-1:0]         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pdf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pdf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pdf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import pdf_pkg::*;

   cfg_type cfg;

   pdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
